>>> rtl/spi_pkg.sv
// Shared widths, result codes and helpers for the segment intersection point unit.
package spi_pkg;

   // coordinate and derived arithmetic widths
   localparam int COORD_BITS  = 24;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int CROSS_BITS  = PROD_BITS + 1;
   localparam int NUM_LO_BITS = (CROSS_BITS + 1) / 2;
   localparam int NUM_HI_BITS = CROSS_BITS - NUM_LO_BITS;
   localparam int DIVD_BITS   = DIFF_BITS + CROSS_BITS;
   localparam int QUO_BITS    = DIFF_BITS;

   // one quotient bit per divider stage
   localparam int DIV_STAGES  = QUO_BITS;

   // front stages: diff, product, cross, decide; then dividend, abs; divider; output
   localparam int DLY_STAGES  = 2 + DIV_STAGES;
   localparam int PIPE_STAGES = 4 + DLY_STAGES + 1;

   // stream widths
   localparam int REQ_DATA_BITS = ((8 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS = 4;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_CROSS = 3'd1,
      KIND_C     = 3'd2,
      KIND_D     = 3'd3,
      KIND_A     = 3'd4,
      KIND_B     = 3'd5
   } hit_kind_type;

   // difference of two coordinates, one bit wider so it never wraps
   function automatic logic signed [DIFF_BITS-1:0] crd_diff(
      input logic signed [COORD_BITS-1:0] p,
      input logic signed [COORD_BITS-1:0] q
   );
      return DIFF_BITS'(p) - DIFF_BITS'(q);
   endfunction

endpackage

>>> rtl/spi_div.sv
// Pipelined restoring divider: one quotient bit per stage, magnitudes in, sign carried.
module spi_div
   import spi_pkg::*;
(
   input  logic                   clock,
   input  logic                   en,
   input  logic [DIVD_BITS-1:0]   num_abs,
   input  logic [CROSS_BITS-1:0]  den_abs,
   input  logic                   neg,
   output logic [QUO_BITS-1:0]    quo_mag,
   output logic                   quo_neg
);

   logic [CROSS_BITS-1:0] rem_ff  [DIV_STAGES];
   logic [QUO_BITS-1:0]   low_ff  [DIV_STAGES];
   logic [CROSS_BITS-1:0] den_ff  [DIV_STAGES];
   logic                  neg_ff  [DIV_STAGES];

   logic [CROSS_BITS-1:0] rem_in  [DIV_STAGES];
   logic [QUO_BITS-1:0]   low_in  [DIV_STAGES];
   logic [CROSS_BITS-1:0] den_in  [DIV_STAGES];
   logic                  neg_in  [DIV_STAGES];

   logic [CROSS_BITS-1:0] rem_src [DIV_STAGES];
   logic [QUO_BITS-1:0]   low_src [DIV_STAGES];
   logic [CROSS_BITS:0]   trial   [DIV_STAGES];
   logic [CROSS_BITS:0]   diff    [DIV_STAGES];
   logic                  ge      [DIV_STAGES];

   // each stage shifts in one dividend bit and retires one quotient bit;
   // low word holds unused dividend bits at the top, quotient bits at the bottom
   always_comb begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            rem_src[k] = num_abs[DIVD_BITS-1:QUO_BITS];
            low_src[k] = num_abs[QUO_BITS-1:0];
            den_in[k]  = den_abs;
            neg_in[k]  = neg;
         end else begin
            rem_src[k] = rem_ff[k-1];
            low_src[k] = low_ff[k-1];
            den_in[k]  = den_ff[k-1];
            neg_in[k]  = neg_ff[k-1];
         end
         trial[k]  = {rem_src[k], low_src[k][QUO_BITS-1]};
         diff[k]   = trial[k] - {1'b0, den_in[k]};
         ge[k]     = trial[k] >= {1'b0, den_in[k]};
         rem_in[k] = ge[k] ? diff[k][CROSS_BITS-1:0] : trial[k][CROSS_BITS-1:0];
         low_in[k] = {low_src[k][QUO_BITS-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            den_ff[k] <= den_in[k];
            neg_ff[k] <= neg_in[k];
         end
      end
   end

   assign quo_mag = low_ff[DIV_STAGES-1];
   assign quo_neg = neg_ff[DIV_STAGES-1];

endmodule

>>> rtl/segment_intersection_point_unit.sv
// Top level of the segment intersection point unit: orientation tests, endpoint checks, hit point.
//
//   channel | direction | tdata                         | tuser
//   req     | in        | A.x A.y B.x B.y C.x C.y D.x D.y | -
//   rsp     | out       | hit_x hit_y (zero padded)     | hit, hit_kind
//
// PIPE_STAGES counts the pipeline stages: four front stages (differences,
// products, cross sums, decision), two dividend stages, one stage per quotient
// bit in the divider, and the output register.
// One item enters per cycle unless stalled. The whole pipeline advances together whenever the
// output register is empty or being taken, so a stall holds every stage.
// Reset clears the valid bits only.
module segment_intersection_point_unit
   import spi_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // A.x, A.y, B.x, B.y, C.x, C.y, D.x, D.y, COORD_BITS each
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // hit_x, hit_y, zero pad
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // hit, hit_kind[2:0]
   output logic [RSP_USER_BITS-1:0]  rsp_tuser
);

   logic en;
   logic vld_ff [PIPE_STAGES];

   // pipeline advance and valid chain
   assign en         = !vld_ff[PIPE_STAGES-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[PIPE_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_STAGES; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < PIPE_STAGES; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // ---------------- stage 1: unpack and differences ----------------
   logic signed [COORD_BITS-1:0] crd_in [8];
   logic signed [COORD_BITS-1:0] crd1_ff [8];
   logic signed [DIFF_BITS-1:0]  v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic signed [DIFF_BITS-1:0]  rx_ff, ry_ff, wx_ff, wy_ff, ux_ff, uy_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) crd_in[i] = req_tdata[i*COORD_BITS +: COORD_BITS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 8; i++) crd1_ff[i] <= crd_in[i];
         v1x_ff <= crd_diff(crd_in[2], crd_in[0]);
         v1y_ff <= crd_diff(crd_in[3], crd_in[1]);
         v2x_ff <= crd_diff(crd_in[6], crd_in[4]);
         v2y_ff <= crd_diff(crd_in[7], crd_in[5]);
         rx_ff  <= crd_diff(crd_in[4], crd_in[0]);
         ry_ff  <= crd_diff(crd_in[5], crd_in[1]);
         wx_ff  <= crd_diff(crd_in[6], crd_in[0]);
         wy_ff  <= crd_diff(crd_in[7], crd_in[1]);
         ux_ff  <= crd_diff(crd_in[2], crd_in[4]);
         uy_ff  <= crd_diff(crd_in[3], crd_in[5]);
      end
   end

   // ---------------- stage 2: products and bounding boxes ----------------
   function automatic logic box_hit(
      input logic signed [COORD_BITS-1:0] px, input logic signed [COORD_BITS-1:0] py,
      input logic signed [COORD_BITS-1:0] qx, input logic signed [COORD_BITS-1:0] qy,
      input logic signed [COORD_BITS-1:0] sx, input logic signed [COORD_BITS-1:0] sy
   );
      return ((sx >= px && sx <= qx) || (sx >= qx && sx <= px)) &&
             ((sy >= py && sy <= qy) || (sy >= qy && sy <= py));
   endfunction

   logic signed [PROD_BITS-1:0] p1a_ff, p1b_ff, p2a_ff, p2b_ff, p3a_ff, p3b_ff;
   logic signed [PROD_BITS-1:0] p4a_ff, p4b_ff, pda_ff, pdb_ff;
   logic signed [PROD_BITS-1:0] p1a_in, p1b_in, p2a_in, p2b_in, p3a_in, p3b_in;
   logic signed [PROD_BITS-1:0] p4a_in, p4b_in, pda_in, pdb_in;
   logic [3:0]                  box2_ff;
   logic [3:0]                  box2_in;
   logic signed [COORD_BITS-1:0] crd2_ff [8];
   logic signed [DIFF_BITS-1:0]  v1x2_ff, v1y2_ff;

   always_comb begin
      p1a_in = v1x_ff * ry_ff;
      p1b_in = v1y_ff * rx_ff;
      p2a_in = v1x_ff * wy_ff;
      p2b_in = v1y_ff * wx_ff;
      p3a_in = v2y_ff * rx_ff;
      p3b_in = v2x_ff * ry_ff;
      p4a_in = v2x_ff * uy_ff;
      p4b_in = v2y_ff * ux_ff;
      pda_in = v1x_ff * v2y_ff;
      pdb_in = v1y_ff * v2x_ff;
      // C in box AB, D in box AB, A in box CD, B in box CD
      box2_in[0] = box_hit(crd1_ff[0], crd1_ff[1], crd1_ff[2], crd1_ff[3],
                           crd1_ff[4], crd1_ff[5]);
      box2_in[1] = box_hit(crd1_ff[0], crd1_ff[1], crd1_ff[2], crd1_ff[3],
                           crd1_ff[6], crd1_ff[7]);
      box2_in[2] = box_hit(crd1_ff[4], crd1_ff[5], crd1_ff[6], crd1_ff[7],
                           crd1_ff[0], crd1_ff[1]);
      box2_in[3] = box_hit(crd1_ff[4], crd1_ff[5], crd1_ff[6], crd1_ff[7],
                           crd1_ff[2], crd1_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1a_ff <= p1a_in; p1b_ff <= p1b_in;
         p2a_ff <= p2a_in; p2b_ff <= p2b_in;
         p3a_ff <= p3a_in; p3b_ff <= p3b_in;
         p4a_ff <= p4a_in; p4b_ff <= p4b_in;
         pda_ff <= pda_in; pdb_ff <= pdb_in;
         box2_ff <= box2_in;
         for (int i = 0; i < 8; i++) crd2_ff[i] <= crd1_ff[i];
         v1x2_ff <= v1x_ff;
         v1y2_ff <= v1y_ff;
      end
   end

   // ---------------- stage 3: cross sums ----------------
   // o3 equals Cramer's numerator
   logic signed [CROSS_BITS-1:0] o1_ff, o2_ff, o3_ff, o4_ff, det3_ff;
   logic [3:0]                   box3_ff;
   logic signed [COORD_BITS-1:0] crd3_ff [8];
   logic signed [DIFF_BITS-1:0]  v1x3_ff, v1y3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         o1_ff   <= CROSS_BITS'(p1a_ff) - CROSS_BITS'(p1b_ff);
         o2_ff   <= CROSS_BITS'(p2a_ff) - CROSS_BITS'(p2b_ff);
         o3_ff   <= CROSS_BITS'(p3a_ff) - CROSS_BITS'(p3b_ff);
         o4_ff   <= CROSS_BITS'(p4a_ff) - CROSS_BITS'(p4b_ff);
         det3_ff <= CROSS_BITS'(pda_ff) - CROSS_BITS'(pdb_ff);
         box3_ff <= box2_ff;
         for (int i = 0; i < 8; i++) crd3_ff[i] <= crd2_ff[i];
         v1x3_ff <= v1x2_ff;
         v1y3_ff <= v1y2_ff;
      end
   end

   // ---------------- stage 4: decision and split numerator products ----------------
   localparam int LO_PROD_BITS = DIFF_BITS + NUM_LO_BITS + 1;
   localparam int HI_PROD_BITS = DIFF_BITS + NUM_HI_BITS;

   logic                         z1, z2, z3, z4, cross_hit;
   logic signed [NUM_LO_BITS:0]  num_lo;
   logic signed [NUM_HI_BITS-1:0] num_hi;
   hit_kind_type                 kind_in;
   logic signed [COORD_BITS-1:0] px_in, py_in;
   logic signed [LO_PROD_BITS-1:0] xlo_ff, ylo_ff, xlo_in, ylo_in;
   logic signed [HI_PROD_BITS-1:0] xhi_ff, yhi_ff, xhi_in, yhi_in;
   logic signed [CROSS_BITS-1:0] det4_ff;
   hit_kind_type                 kind4_ff;
   logic signed [COORD_BITS-1:0] px4_ff, py4_ff;

   always_comb begin
      z1 = (o1_ff == '0);
      z2 = (o2_ff == '0);
      z3 = (o3_ff == '0);
      z4 = (o4_ff == '0);
      // both pairs of orientations nonzero and opposite
      cross_hit = !z1 && !z2 && (o1_ff[CROSS_BITS-1] != o2_ff[CROSS_BITS-1]) &&
                  !z3 && !z4 && (o3_ff[CROSS_BITS-1] != o4_ff[CROSS_BITS-1]);

      // endpoint priority C, D, A, B
      if (cross_hit) begin
         kind_in = KIND_CROSS; px_in = crd3_ff[0]; py_in = crd3_ff[1];
      end else if (z1 && box3_ff[0]) begin
         kind_in = KIND_C;     px_in = crd3_ff[4]; py_in = crd3_ff[5];
      end else if (z2 && box3_ff[1]) begin
         kind_in = KIND_D;     px_in = crd3_ff[6]; py_in = crd3_ff[7];
      end else if (z3 && box3_ff[2]) begin
         kind_in = KIND_A;     px_in = crd3_ff[0]; py_in = crd3_ff[1];
      end else if (z4 && box3_ff[3]) begin
         kind_in = KIND_B;     px_in = crd3_ff[2]; py_in = crd3_ff[3];
      end else begin
         kind_in = KIND_NONE;  px_in = '0;         py_in = '0;
      end

      // numerator split in an unsigned low half and a signed high half
      num_lo = {1'b0, o3_ff[NUM_LO_BITS-1:0]};
      num_hi = o3_ff[CROSS_BITS-1:NUM_LO_BITS];
      xlo_in = v1x3_ff * num_lo;
      ylo_in = v1y3_ff * num_lo;
      xhi_in = v1x3_ff * num_hi;
      yhi_in = v1y3_ff * num_hi;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xlo_ff   <= xlo_in;
         ylo_ff   <= ylo_in;
         xhi_ff   <= xhi_in;
         yhi_ff   <= yhi_in;
         det4_ff  <= det3_ff;
         kind4_ff <= kind_in;
         px4_ff   <= px_in;
         py4_ff   <= py_in;
      end
   end

   // ---------------- stage 5: full dividends ----------------
   logic signed [DIVD_BITS-1:0]  nx5_ff, ny5_ff;
   logic signed [CROSS_BITS-1:0] det5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nx5_ff  <= (DIVD_BITS'(xhi_ff) <<< NUM_LO_BITS) + DIVD_BITS'(xlo_ff);
         ny5_ff  <= (DIVD_BITS'(yhi_ff) <<< NUM_LO_BITS) + DIVD_BITS'(ylo_ff);
         det5_ff <= det4_ff;
      end
   end

   // ---------------- stage 6: magnitudes and quotient signs ----------------
   logic [DIVD_BITS-1:0]  nx6_ff, ny6_ff;
   logic [CROSS_BITS-1:0] det6_ff;
   logic                  negx6_ff, negy6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nx6_ff   <= nx5_ff[DIVD_BITS-1] ? DIVD_BITS'(-nx5_ff) : DIVD_BITS'(nx5_ff);
         ny6_ff   <= ny5_ff[DIVD_BITS-1] ? DIVD_BITS'(-ny5_ff) : DIVD_BITS'(ny5_ff);
         det6_ff  <= det5_ff[CROSS_BITS-1] ? CROSS_BITS'(-det5_ff) : CROSS_BITS'(det5_ff);
         negx6_ff <= nx5_ff[DIVD_BITS-1] ^ det5_ff[CROSS_BITS-1];
         negy6_ff <= ny5_ff[DIVD_BITS-1] ^ det5_ff[CROSS_BITS-1];
      end
   end

   // ---------------- dividers ----------------
   logic [QUO_BITS-1:0] qx_mag, qy_mag;
   logic                qx_neg, qy_neg;

   spi_div u_div_x (
      .clock   (clock),
      .en      (en),
      .num_abs (nx6_ff),
      .den_abs (det6_ff),
      .neg     (negx6_ff),
      .quo_mag (qx_mag),
      .quo_neg (qx_neg)
   );

   spi_div u_div_y (
      .clock   (clock),
      .en      (en),
      .num_abs (ny6_ff),
      .den_abs (det6_ff),
      .neg     (negy6_ff),
      .quo_mag (qy_mag),
      .quo_neg (qy_neg)
   );

   // kind and base point ride alongside stages 5, 6 and the divider
   hit_kind_type                 kind_d_ff [DLY_STAGES];
   logic signed [COORD_BITS-1:0] px_d_ff   [DLY_STAGES];
   logic signed [COORD_BITS-1:0] py_d_ff   [DLY_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         kind_d_ff[0] <= kind4_ff;
         px_d_ff[0]   <= px4_ff;
         py_d_ff[0]   <= py4_ff;
         for (int k = 1; k < DLY_STAGES; k++) begin
            kind_d_ff[k] <= kind_d_ff[k-1];
            px_d_ff[k]   <= px_d_ff[k-1];
            py_d_ff[k]   <= py_d_ff[k-1];
         end
      end
   end

   // ---------------- output register ----------------
   logic signed [QUO_BITS:0]     qx_s, qy_s;
   logic signed [COORD_BITS-1:0] hx_in, hy_in, hx_ff, hy_ff;
   hit_kind_type                 kind_ff;

   always_comb begin
      qx_s = qx_neg ? -$signed({1'b0, qx_mag}) : $signed({1'b0, qx_mag});
      qy_s = qy_neg ? -$signed({1'b0, qy_mag}) : $signed({1'b0, qy_mag});
      if (kind_d_ff[DLY_STAGES-1] == KIND_CROSS) begin
         hx_in = px_d_ff[DLY_STAGES-1] + qx_s[COORD_BITS-1:0];
         hy_in = py_d_ff[DLY_STAGES-1] + qy_s[COORD_BITS-1:0];
      end else begin
         hx_in = px_d_ff[DLY_STAGES-1];
         hy_in = py_d_ff[DLY_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hx_ff   <= hx_in;
         hy_ff   <= hy_in;
         kind_ff <= kind_d_ff[DLY_STAGES-1];
      end
   end

   assign rsp_tdata = RSP_DATA_BITS'({hy_ff, hx_ff});
   assign rsp_tuser = {kind_ff, (kind_ff != KIND_NONE)};

endmodule
